FILE: rtl/core/utf8_stream_decoder_defines.svh
// assertion macros shared by the utf8 stream decoder checkers
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define U8SD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8sd assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define U8SD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8sd assertion failed");

`endif

FILE: rtl/core/u8sd_pkg.sv
// types and constants shared by the utf8 stream decoder modules
package u8sd_pkg;

  localparam int CP_W  = 31;
  localparam int CNT_W = 3;

  localparam logic [CP_W-1:0] SUBST_CHAR = 31'd63;

  // one input transaction
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_t;

  // one result transaction
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            end_of_run;
  } out_t;

  // results of one byte: cnt results, all substitutes except the last, which is cp
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0]  cp;
  } desc_t;

endpackage

FILE: rtl/core/utf8_stream_decoder.sv
// Streaming decoder for legacy UTF-8 (one to six byte forms, 31-bit code points).
//
// Input channel in_valid/in_stall/in_data carries one byte and a last_byte flag.
// Result channel out_valid/out_stall/out_data carries a code point and end_of_run,
// which marks the final result caused by one input byte.
// A byte that cannot be used yields 63 for the lead byte and each buffered
// continuation byte; the breaking byte is then decoded again as a new byte.
// A result passes the input register and then the result register to out_valid.
// Throughput: one byte per cycle while out_stall is low and each byte causes
// at most one result; a byte causing n results (n at most six) holds the result
// register until all are taken, and bytes that only extend a sequence yield none.
// in_stall comes from a two-entry input stage (register plus skid) and rises in
// the cycle after a byte is taken while the decode stage is blocked.
// When out_stall is high the result register holds its transaction; the input
// stage fills and then raises in_stall.
// Reset (rst_n low, synchronous) empties both stages and closes any open sequence.
module utf8_stream_decoder
  import u8sd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  desc_t desc;
  logic  desc_vld;
  logic  desc_ready;

  // byte decode and sequence state
  u8sd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .desc_vld   (desc_vld),
    .desc       (desc),
    .desc_ready (desc_ready)
  );

  // result playout
  u8sd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_vld   (desc_vld),
    .desc       (desc),
    .desc_ready (desc_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: rtl/core/u8sd_decode.sv
// input skid stage, sequence state and per-byte decode
module u8sd_decode
  import u8sd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  in_t   in_data,
  output logic  in_stall,
  output logic  desc_vld,
  output desc_t desc,
  input  logic  desc_ready
);

  logic            main_vld_r;
  in_t             main_r;
  logic            skid_vld_r;
  in_t             skid_r;
  logic [CP_W-1:0] part_r, part_nxt;
  logic [2:0]      due_r, due_nxt;
  logic [2:0]      held_r, held_nxt;

  logic            in_fire;
  logic            adv;
  logic            cont;
  logic [CP_W-1:0] pc_ext;
  logic [2:0]      due_dec;
  logic [2:0]      held_inc;
  logic [2:0]      flush_n;
  logic            f_lead;
  logic [2:0]      f_extra;
  logic [CP_W-1:0] f_bits;
  logic [CP_W-1:0] f_cp;
  logic [CNT_W-1:0] cnt;
  logic [CP_W-1:0] cp;

  assign in_stall = skid_vld_r;
  assign in_fire  = in_valid && !skid_vld_r;

  // classify the byte and work out results and next state
  always_comb begin
    cont     = (main_r.byte_in[7:6] == 2'b10);
    pc_ext   = {part_r[CP_W-7:0], main_r.byte_in[5:0]};
    due_dec  = due_r - 3'd1;
    held_inc = held_r + 3'd1;
    flush_n  = (due_r != 3'd0) ? held_r : 3'd0;

    f_lead  = 1'b0;
    f_extra = 3'd0;
    f_bits  = '0;
    f_cp    = SUBST_CHAR;
    case (main_r.byte_in) inside
      [8'h00:8'h7F]: f_cp = {23'd0, main_r.byte_in};
      [8'hC0:8'hDF]: begin
        f_lead = 1'b1; f_extra = 3'd1; f_bits = {26'd0, main_r.byte_in[4:0]};
      end
      [8'hE0:8'hEF]: begin
        f_lead = 1'b1; f_extra = 3'd2; f_bits = {27'd0, main_r.byte_in[3:0]};
      end
      [8'hF0:8'hF7]: begin
        f_lead = 1'b1; f_extra = 3'd3; f_bits = {28'd0, main_r.byte_in[2:0]};
      end
      [8'hF8:8'hFB]: begin
        f_lead = 1'b1; f_extra = 3'd4; f_bits = {29'd0, main_r.byte_in[1:0]};
      end
      [8'hFC:8'hFD]: begin
        f_lead = 1'b1; f_extra = 3'd5; f_bits = {30'd0, main_r.byte_in[0]};
      end
      default: ;  // stray continuation or invalid lead: one substitute
    endcase

    cnt      = '0;
    cp       = SUBST_CHAR;
    part_nxt = '0;
    due_nxt  = 3'd0;
    held_nxt = 3'd0;
    if (due_r != 3'd0 && cont) begin
      // continuation byte of an open sequence
      if (due_dec == 3'd0) begin
        cnt = 3'd1;
        cp  = pc_ext;
      end else if (main_r.last_byte) begin
        cnt = held_inc;
      end else begin
        part_nxt = pc_ext;
        due_nxt  = due_dec;
        held_nxt = held_inc;
      end
    end else begin
      // flush whatever is open, then decode this byte afresh
      if (f_lead && !main_r.last_byte) begin
        cnt      = flush_n;
        part_nxt = f_bits;
        due_nxt  = f_extra;
        held_nxt = 3'd1;
      end else begin
        cnt = flush_n + 3'd1;
        cp  = f_cp;
      end
    end
  end

  assign adv       = main_vld_r && ((cnt == '0) || desc_ready);
  assign desc_vld  = main_vld_r && (cnt != '0);
  assign desc.cnt  = cnt;
  assign desc.cp   = cp;

  // input stage with skid register, and sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
      part_r     <= '0;
      due_r      <= 3'd0;
      held_r     <= 3'd0;
    end else begin
      if (!main_vld_r || adv) begin
        main_vld_r <= skid_vld_r || in_fire;
        main_r     <= skid_vld_r ? skid_r : in_data;
        skid_vld_r <= 1'b0;
      end else if (in_fire) begin
        skid_r     <= in_data;
        skid_vld_r <= 1'b1;
      end
      if (adv) begin
        part_r <= part_nxt;
        due_r  <= due_nxt;
        held_r <= held_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/u8sd_emit.sv
// result register that plays out the results of one byte, one per cycle while out_stall is low
module u8sd_emit
  import u8sd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  desc_vld,
  input  desc_t desc,
  output logic  desc_ready,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  logic [CNT_W-1:0] rem_r;
  logic [CP_W-1:0]  cp_r;
  logic             busy;
  logic             out_fire;
  logic             tail;

  assign busy       = (rem_r != '0);
  assign tail       = (rem_r == CNT_W'(1));
  assign out_fire   = busy && !out_stall;
  assign desc_ready = !busy || (out_fire && tail);

  // substitutes first, the tail value last
  assign out_valid           = busy;
  assign out_data.code_point = tail ? cp_r : SUBST_CHAR;
  assign out_data.end_of_run = tail;

  // count down remaining results, reload when idle or on the tail transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (desc_vld && desc_ready) begin
      rem_r <= desc.cnt;
      cp_r  <= desc.cp;
    end else if (out_fire) begin
      rem_r <= rem_r - CNT_W'(1);
    end
  end

endmodule

FILE: rtl/core/u8sd_checker.sv
// port-level checker for the utf8 stream decoder, bound to the top level
`include "utf8_stream_decoder_defines.svh"

module u8sd_checker
  import u8sd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // a stalled result transaction stays offered
  `U8SD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

  // a stalled result transaction keeps its payload
  `U8SD_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data))

  // every result except the last of a byte is a substitute
  `U8SD_ASSERT_IMP(a_subst, out_valid && !out_data.end_of_run,
                   out_data.code_point == SUBST_CHAR)

  // the input stage only stalls after it has taken a transaction
  `U8SD_ASSERT_IMP(a_stall_cause, $rose(in_stall), $past(in_valid && !in_stall))

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
